// File: hdl/dmsp_pkg.sv
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared types and constants of the dual motor speed PID core: register
// indexes, configuration record, controller command and status records.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsp_pkg;

    // defaults of the top level parameters
    localparam int MOTOR_COUNT_DEF = 2;
    localparam int GAIN_FRAC_DEF   = 12;

    // fixed field widths
    localparam int GAIN_W   = 16;
    localparam int TGT_W    = 16;
    localparam int SCALE_W  = 24;
    localparam int DRV_W    = 16;
    localparam int MIND_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // speed divider and accumulator widths
    localparam int DIV_W    = 40;
    localparam int DIV_CNT_W = 6;
    localparam int ACC_W    = 60;
    localparam int MAC_STEPS = 6;
    localparam int MAC_CNT_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_TARGET_A  = 3'd3,
        CFG_TARGET_B  = 3'd4,
        CFG_SCALE     = 3'd5,
        CFG_MAX_DRIVE = 3'd6,
        CFG_MIN_DRIVE = 3'd7
    } dmsp_cfg_idx_t;

    // term chosen by the shared multiplier
    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } dmsp_term_t;

    typedef struct packed {
        logic        [GAIN_W-1:0]  gain_p;
        logic        [GAIN_W-1:0]  gain_i;
        logic        [GAIN_W-1:0]  gain_d;
        logic signed [TGT_W-1:0]   target_a;
        logic signed [TGT_W-1:0]   target_b;
        logic        [SCALE_W-1:0] speed_scale;
        logic        [DRV_W-1:0]   max_drive;
        logic signed [MIND_W-1:0]  min_drive;
    } dmsp_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scale;
        logic       div_start;
        logic       speed;
        logic       err;
        logic       integ;
        logic       mac_mul;
        logic       mac_acc;
        dmsp_term_t mac_term;
        logic       mac_hi;
        logic       absval;
        logic       clamp;
        logic       out_load;
    } dmsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic motor_ok;
        logic div_done;
        logic out_free;
    } dmsp_sts_t;

endpackage

`default_nettype wire

// File: hdl/dual_motor_speed_pid_core.sv
// ----------------------------------------------------------------------------
// dual_motor_speed_pid_core
// Two-motor PID speed controller: configuration registers, controller and
// datapath.
// ----------------------------------------------------------------------------
// Each input transfer is one control tick for motor A or B; the block returns
// one result transfer per tick with the measured speed (enc_delta times
// speed_scale over period_ms, Q23.8, saturated), the clamped control value,
// its direction and PWM magnitude. One item is in work at a time: a tick
// passes the speed product, the one-bit-per-cycle speed divider (40 quotient
// bits), the error and integral steps and the shared 17 x 21 bit multiplier
// that builds the PID sum in six partial products, then the clamp and the
// result register. The next tick is taken as soon as the controller is back
// in idle, even while the last result still waits to be taken. A tick for a
// motor number at or above MOTOR_COUNT is dropped in the scale state after
// its transfer, without a result. A zero target clears that motor's integral
// and prior error at the integral step. Registers are to be written only while
// no tick is in work; the block does not enforce it. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_motor_speed_pid_core
    import dmsp_pkg::*;
#(
    parameter int MOTOR_COUNT    = MOTOR_COUNT_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    // control ticks
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 motor,
    input  wire logic signed [15:0]   enc_delta,
    input  wire logic [15:0]          period_ms,
    // results
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      motor_out,
    output logic                      forward,
    output logic [15:0]               pwm_level,
    output logic signed [31:0]        measured_speed,
    output logic signed [16:0]        control_value
);

    dmsp_cfg_t cfg_reg;
    dmsp_cmd_t cmd;
    dmsp_sts_t sts;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p      <= 16'd4096;
            cfg_reg.gain_i      <= 16'd410;
            cfg_reg.gain_d      <= 16'd205;
            cfg_reg.target_a    <= '0;
            cfg_reg.target_b    <= '0;
            cfg_reg.speed_scale <= 24'd256;
            cfg_reg.max_drive   <= 16'hffff;
            cfg_reg.min_drive   <= 17'h10001;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dmsp_cfg_idx_t'(cfg_index))
                CFG_GAIN_P:    cfg_reg.gain_p      <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    cfg_reg.gain_i      <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    cfg_reg.gain_d      <= cfg_data[GAIN_W-1:0];
                CFG_TARGET_A:  cfg_reg.target_a    <= $signed(cfg_data[TGT_W-1:0]);
                CFG_TARGET_B:  cfg_reg.target_b    <= $signed(cfg_data[TGT_W-1:0]);
                CFG_SCALE:     cfg_reg.speed_scale <= cfg_data[SCALE_W-1:0];
                CFG_MAX_DRIVE: cfg_reg.max_drive   <= cfg_data[DRV_W-1:0];
                CFG_MIN_DRIVE: cfg_reg.min_drive   <= $signed(cfg_data[MIND_W-1:0]);
                default:       cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // tick sequencer
    dmsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and result register
    dmsp_dp #(
        .MOTOR_COUNT    (MOTOR_COUNT),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg            (cfg_reg),
        .motor          (motor),
        .enc_delta      (enc_delta),
        .period_ms      (period_ms),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .motor_out      (motor_out),
        .forward        (forward),
        .pwm_level      (pwm_level),
        .measured_speed (measured_speed),
        .control_value  (control_value)
    );

endmodule

`default_nettype wire

// File: hdl/dmsp_div.sv
// ----------------------------------------------------------------------------
// dmsp_div
// Restoring divider, one quotient bit per cycle, for the speed quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_div
    import dmsp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [15:0]      divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [15:0]          rem_reg;
    logic [15:0]          dsr_reg;

    logic [17:0]          diff_next;

    // trial subtract of the divisor from the shifted remainder
    assign diff_next = {1'b0, rem_reg, quo_reg[DIV_W-1]} - {2'b00, dsr_reg};

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (diff_next[17])
            begin
                rem_reg <= {rem_reg[14:0], quo_reg[DIV_W-1]};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= diff_next[15:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/dmsp_dp.sv
// ----------------------------------------------------------------------------
// dmsp_dp
// Datapath: speed product and quotient, error, integral and derivative,
// shared multiply-accumulate for the PID sum, truncation, clamp and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_dp
    import dmsp_pkg::*;
#(
    parameter int MOTOR_COUNT    = MOTOR_COUNT_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dmsp_cmd_t          cmd,
    output dmsp_sts_t               sts,
    input  wire dmsp_cfg_t          cfg,
    input  wire logic               motor,
    input  wire logic signed [15:0] enc_delta,
    input  wire logic [15:0]        period_ms,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic                    motor_out,
    output logic                    forward,
    output logic [15:0]             pwm_level,
    output logic signed [31:0]      measured_speed,
    output logic signed [16:0]      control_value
);

    localparam int SHIFT = 8 + GAIN_FRAC_BITS;

    localparam logic signed [40:0] S41_MAX32 = 41'sd2147483647;
    localparam logic signed [40:0] S41_MIN32 = -41'sd2147483648;
    localparam logic signed [33:0] S34_MAX32 = 34'sd2147483647;
    localparam logic signed [33:0] S34_MIN32 = -34'sd2147483648;
    localparam logic signed [40:0] S41_MAX40 = 41'sd549755813887;
    localparam logic signed [40:0] S41_MIN40 = -41'sd549755813888;

    // captured item
    logic               motor_reg;
    logic               motor_ok_reg;
    logic signed [15:0] delta_reg;
    logic [15:0]        period_reg;

    // working values
    logic signed [40:0] prod_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] err_reg;
    logic signed [39:0] integ_w_reg;
    logic signed [32:0] deriv_reg;
    logic signed [37:0] mprod_reg;
    logic               mhi_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0]   mag_reg;
    logic               neg_reg;
    logic signed [16:0] ctl_reg;

    // per motor state
    logic signed [39:0] integ_st_reg [MOTOR_COUNT];
    logic signed [31:0] prior_st_reg [MOTOR_COUNT];

    // result register
    logic               out_valid_reg;
    logic               motor_out_reg;
    logic               forward_reg;
    logic [15:0]        pwm_reg;
    logic signed [31:0] speed_out_reg;
    logic signed [16:0] ctl_out_reg;

    logic signed [40:0] prod_next;
    logic [DIV_W-1:0]   dividend;
    logic               div_done;
    logic [DIV_W-1:0]   quotient;
    logic signed [40:0] quo_s;
    logic signed [31:0] speed_next;
    logic signed [TGT_W-1:0] target;
    logic signed [33:0] diff34;
    logic signed [31:0] err_next;
    logic signed [39:0] integ_cur;
    logic signed [31:0] prior_cur;
    logic signed [40:0] isum41;
    logic signed [39:0] integ_next;
    logic signed [32:0] deriv_next;
    logic [GAIN_W-1:0]  mgain;
    logic signed [40:0] mopnd;
    logic signed [20:0] mchunk;
    logic signed [37:0] mprod_next;
    logic signed [ACC_W-1:0] maddend;
    logic signed [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0]   mag_next;
    logic [ACC_W-1:0]   shifted;
    logic signed [ACC_W:0] ctl_wide;
    logic signed [ACC_W:0] maxd_wide;
    logic signed [ACC_W:0] mind_wide;
    logic signed [16:0] ctl_next;
    logic [16:0]        ctl_negated;
    logic [15:0]        pwm_next;
    logic               out_take;

    // speed product and divider operands
    assign prod_next = delta_reg * $signed({1'b0, cfg.speed_scale});
    assign dividend  = prod_reg[40] ? DIV_W'(-prod_reg) : prod_reg[DIV_W-1:0];

    dmsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // signed quotient saturated to 32 bits
    always_comb
    begin
        quo_s = prod_reg[40] ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        if (quo_s > S41_MAX32)
            speed_next = 32'sh7fffffff;
        else if (quo_s < S41_MIN32)
            speed_next = 32'sh80000000;
        else
            speed_next = quo_s[31:0];
    end

    // error against the selected target
    always_comb
    begin
        target = motor_reg ? cfg.target_b : cfg.target_a;
        diff34 = $signed({{10{target[TGT_W-1]}}, target, 8'h00})
               - $signed({{2{speed_reg[31]}}, speed_reg});
        if (diff34 > S34_MAX32)
            err_next = 32'sh7fffffff;
        else if (diff34 < S34_MIN32)
            err_next = 32'sh80000000;
        else
            err_next = diff34[31:0];
    end

    // state of the ticked motor
    always_comb
    begin
        integ_cur = '0;
        prior_cur = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            if (motor_reg == 1'(i))
            begin
                integ_cur = integ_st_reg[i];
                prior_cur = prior_st_reg[i];
            end
        end
    end

    // saturating integral and derivative
    always_comb
    begin
        isum41 = $signed({integ_cur[39], integ_cur})
               + $signed({{9{err_reg[31]}}, err_reg});
        if (isum41 > S41_MAX40)
            integ_next = {1'b0, {39{1'b1}}};
        else if (isum41 < S41_MIN40)
            integ_next = {1'b1, 39'h0};
        else
            integ_next = isum41[39:0];
        deriv_next = $signed({err_reg[31], err_reg}) - $signed({prior_cur[31], prior_cur});
    end

    // shared multiplier: gain times the low 20 bits or the upper 21 bits of the term
    always_comb
    begin
        unique case (cmd.mac_term)
            TERM_P:
            begin
                mgain = cfg.gain_p;
                mopnd = $signed({{9{err_reg[31]}}, err_reg});
            end
            TERM_I:
            begin
                mgain = cfg.gain_i;
                mopnd = $signed({integ_w_reg[39], integ_w_reg});
            end
            TERM_D:
            begin
                mgain = cfg.gain_d;
                mopnd = $signed({{8{deriv_reg[32]}}, deriv_reg});
            end
            default:
            begin
                mgain = '0;
                mopnd = '0;
            end
        endcase
        mchunk     = cmd.mac_hi ? mopnd[40:20] : $signed({1'b0, mopnd[19:0]});
        mprod_next = $signed({1'b0, mgain}) * mchunk;
    end

    // accumulate, upper slices weighted by 2^20
    always_comb
    begin
        maddend = $signed({{(ACC_W-38){mprod_reg[37]}}, mprod_reg});
        if (mhi_reg)
            maddend = maddend <<< 20;
        acc_next = acc_reg + maddend;
        mag_next = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    end

    // truncate toward zero and clamp to the drive limits
    always_comb
    begin
        shifted   = mag_reg >> SHIFT;
        ctl_wide  = neg_reg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
        maxd_wide = $signed({{(ACC_W+1-DRV_W){1'b0}}, cfg.max_drive});
        mind_wide = $signed({{(ACC_W+1-MIND_W){cfg.min_drive[MIND_W-1]}}, cfg.min_drive});
        if (ctl_wide > maxd_wide)
            ctl_next = $signed({1'b0, cfg.max_drive});
        else if (ctl_wide < mind_wide)
            ctl_next = cfg.min_drive;
        else
            ctl_next = ctl_wide[16:0];
    end

    // magnitude, saturated for the most negative control
    always_comb
    begin
        ctl_negated = 17'(-ctl_reg);
        if (!ctl_reg[16])
            pwm_next = ctl_reg[15:0];
        else if (ctl_negated[16])
            pwm_next = 16'hffff;
        else
            pwm_next = ctl_negated[15:0];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            motor_reg  <= motor;
            delta_reg  <= enc_delta;
            period_reg <= (period_ms == '0) ? 16'd1 : period_ms;
        end
        if (cmd.scale)
            prod_reg <= prod_next;
        if (cmd.speed)
            speed_reg <= speed_next;
        if (cmd.err)
            err_reg <= err_next;
        if (cmd.integ)
        begin
            integ_w_reg <= integ_next;
            deriv_reg   <= deriv_next;
        end
        if (cmd.mac_mul)
        begin
            mprod_reg <= mprod_next;
            mhi_reg   <= cmd.mac_hi;
        end
        if (cmd.absval)
        begin
            mag_reg <= mag_next;
            neg_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.clamp)
            ctl_reg <= ctl_next;
    end

    // accumulator, cleared as the terms become ready
    always_ff @(posedge clk)
    begin
        if (cmd.integ)
            acc_reg <= '0;
        else if (cmd.mac_acc)
            acc_reg <= acc_next;
    end

    // motor present flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            motor_ok_reg <= 1'b0;
        else if (cmd.load)
            motor_ok_reg <= (int'(motor) < MOTOR_COUNT);
    end

    // per motor integral and prior error, cleared on a zero target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                integ_st_reg[i] <= '0;
                prior_st_reg[i] <= '0;
            end
        end
        else if (cmd.integ)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                if (motor_reg == 1'(i))
                begin
                    integ_st_reg[i] <= (target == '0) ? '0 : integ_next;
                    prior_st_reg[i] <= (target == '0) ? '0 : err_reg;
                end
            end
        end
    end

    // result register and its valid flag
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            motor_out_reg <= motor_reg;
            forward_reg   <= !ctl_reg[16];
            pwm_reg       <= pwm_next;
            speed_out_reg <= speed_reg;
            ctl_out_reg   <= ctl_reg;
        end
    end

    assign sts.motor_ok = motor_ok_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign motor_out      = motor_out_reg;
    assign forward        = forward_reg;
    assign pwm_level      = pwm_reg;
    assign measured_speed = speed_out_reg;
    assign control_value  = ctl_out_reg;

endmodule

`default_nettype wire

// File: hdl/dmsp_ctrl.sv
// ----------------------------------------------------------------------------
// dmsp_ctrl
// Controller: sequences one control tick through the datapath, from the
// input transfer to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsp_ctrl
    import dmsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire dmsp_sts_t sts,
    output dmsp_cmd_t      cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_SCALE = 11'b000_0000_0010,
        ST_DIVS  = 11'b000_0000_0100,
        ST_DIVW  = 11'b000_0000_1000,
        ST_SPEED = 11'b000_0001_0000,
        ST_ERR   = 11'b000_0010_0000,
        ST_INTEG = 11'b000_0100_0000,
        ST_MAC   = 11'b000_1000_0000,
        ST_ABS   = 11'b001_0000_0000,
        ST_CLAMP = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } dmsp_state_t;

    dmsp_state_t          state_reg;
    dmsp_state_t          state_next;
    logic [MAC_CNT_W-1:0] mac_cnt_reg;
    logic [MAC_CNT_W-1:0] mac_cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        mac_cnt_next = mac_cnt_reg;
        cmd          = '0;
        cmd.mac_term = dmsp_term_t'(mac_cnt_reg[2:1]);
        cmd.mac_hi   = mac_cnt_reg[0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = sts.motor_ok ? ST_DIVS : ST_IDLE;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (sts.div_done)
                    state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                cmd.speed  = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err    = 1'b1;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.integ    = 1'b1;
                mac_cnt_next = '0;
                state_next   = ST_MAC;
            end
            ST_MAC:
            begin
                // multiply one slice while the previous product accumulates
                cmd.mac_mul  = (mac_cnt_reg != MAC_CNT_W'(MAC_STEPS));
                cmd.mac_acc  = (mac_cnt_reg != '0);
                mac_cnt_next = mac_cnt_reg + 1'b1;
                if (mac_cnt_reg == MAC_CNT_W'(MAC_STEPS))
                    state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.absval = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mac_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mac_cnt_reg <= mac_cnt_next;
        end
    end

endmodule

`default_nettype wire
